// ----- sv/tla_pkg.sv -----
// Shared widths, command codes, register indexes and control structs of the trigger level annealer.
package tla_pkg;

    localparam int LEVEL_W    = 12;
    localparam int DUTY_W     = 13;
    localparam int TEMP_W     = 12;
    localparam int COUNT_W    = 16;
    localparam int RAND_W     = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Quotient register: as wide as the widest product; the divisor as wide as the widest register.
    localparam int DIV_W      = 28;
    localparam int DVSR_W     = 16;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CYCLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_MAX   = 2'd3;

    localparam logic [DVSR_W-1:0] STEP_DIVISOR   = 16'd32767;
    localparam logic [DUTY_W-1:0] DUTY_MAX       = 13'd8191;
    localparam logic [LEVEL_W-1:0] LEARN_MAX_RST = 12'd3300;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic div_serial;
    } t_dp_status;

endpackage

// ----- sv/tla_if.sv -----
// Valid/ready stream interfaces for the command channel and the result channel.
interface tla_in_if import tla_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [CMD_W-1:0]   cmd;
    logic        [LEVEL_W-1:0] set_level;
    logic        [COUNT_W-1:0] valid_count;
    logic signed [RAND_W-1:0]  rand_accept;
    logic signed [RAND_W-1:0]  rand_step;

    modport source (output valid, cmd, set_level, valid_count, rand_accept, rand_step,
                    input ready);
    modport sink   (input valid, cmd, set_level, valid_count, rand_accept, rand_step,
                    output ready);
endinterface

interface tla_out_if import tla_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [LEVEL_W-1:0] level;
    logic [DUTY_W-1:0]  duty_count;
    logic [TEMP_W-1:0]  temperature;
    logic               learning;

    modport source (output valid, accepted, level, duty_count, temperature, learning,
                    input ready);
    modport sink   (input valid, accepted, level, duty_count, temperature, learning,
                    output ready);
endinterface

// ----- sv/tla_datapath.sv -----
// Annealer datapath: configuration, state registers, multipliers, serial divider and result register.
module tla_datapath import tla_pkg::*; #(
    parameter int PWM_WRAP   = 5000,
    parameter int SUPPLY_MV  = 3300,
    parameter int SET_MIN_MV = 0,
    parameter int SET_MAX_MV = 3300,
    parameter int DEFAULT_MV = 1000
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_sts,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [CMD_W-1:0]          i_op,
    input  logic [LEVEL_W-1:0]        i_set_level,
    input  logic [COUNT_W-1:0]        i_valid_count,
    input  logic signed [RAND_W-1:0]  i_rand_accept,
    input  logic signed [RAND_W-1:0]  i_rand_step,
    output logic                      o_accepted,
    output logic [LEVEL_W-1:0]        o_level,
    output logic [DUTY_W-1:0]         o_duty_count,
    output logic [TEMP_W-1:0]         o_temperature,
    output logic                      o_learning
);

    localparam logic [DUTY_W-1:0]  WRAP_K    = DUTY_W'(PWM_WRAP);
    localparam logic [LEVEL_W-1:0] SET_MIN_K = LEVEL_W'(SET_MIN_MV);
    localparam logic [LEVEL_W-1:0] SET_MAX_K = LEVEL_W'(SET_MAX_MV);
    localparam int                 DEFAULT_LVL = DEFAULT_MV % (1 << LEVEL_W);
    localparam logic [LEVEL_W-1:0] DEFAULT_K = LEVEL_W'(DEFAULT_LVL);
    localparam int                 DEFAULT_DUTY_FULL = (DEFAULT_LVL * PWM_WRAP) / SUPPLY_MV;
    localparam logic [DUTY_W-1:0]  DEFAULT_DUTY =
        (DEFAULT_DUTY_FULL > 8191) ? DUTY_MAX : DUTY_W'(DEFAULT_DUTY_FULL);

    // The duty product is below 2^25 and the supply below 2^12, so a 37-bit reciprocal is exact.
    localparam int                 RECIP_SHIFT  = 37;
    localparam longint             RECIP_FULL   =
        ((longint'(1) <<< RECIP_SHIFT) + longint'(SUPPLY_MV) - 1) / longint'(SUPPLY_MV);
    localparam logic [DIV_W-1:0]   SUPPLY_RECIP = DIV_W'(RECIP_FULL);
    localparam int                 STEP_SHIFT   = 15;

    // Configuration registers.
    logic [TEMP_W-1:0]  r_start_temp;
    logic [COUNT_W-1:0] r_cycle_count;
    logic [LEVEL_W-1:0] r_learn_min;
    logic [LEVEL_W-1:0] r_learn_max;

    // Annealer state.
    logic [LEVEL_W-1:0] r_cur_level, n_cur_level;
    logic [LEVEL_W-1:0] r_best_level, n_best_level;
    logic [TEMP_W-1:0]  r_cur_temp, n_cur_temp;
    logic [TEMP_W-1:0]  r_cool_step, n_cool_step;
    logic [COUNT_W-1:0] r_prev_count, n_prev_count;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic               n_ok;

    // Captured input beat.
    logic [CMD_W-1:0]         r_op;
    logic [LEVEL_W-1:0]       r_set_level;
    logic [COUNT_W-1:0]       r_count;
    logic signed [RAND_W-1:0] r_rand_acc;
    logic                     r_step_neg;
    logic [RAND_W-1:0]        r_step_mag;

    // Products.
    logic [DIV_W-1:0]   r_prod;
    logic signed [35:0] r_term1;
    logic signed [32:0] r_term2;

    // Serial divider.
    logic [DIV_W-1:0]     r_div_quo;
    logic [DVSR_W-1:0]    r_div_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [RAND_W-1:0]        w_mult_a;
    logic [DUTY_W-1:0]        w_mult_b;
    logic [28:0]              w_prod;
    logic signed [16:0]       w_delta;
    logic signed [35:0]       w_delta_x;
    logic signed [35:0]       w_term1;
    logic [COUNT_W-1:0]       w_m;
    logic signed [32:0]       w_term2;
    logic [2*DIV_W-1:0]       w_recip_prod;
    logic [DIV_W-1:0]         w_duty_quo;
    logic [DVSR_W-1:0]        w_k_sum;
    logic [DIV_W-1:0]         w_step_quo;
    logic [DIV_W-1:0]         w_dividend;
    logic [DVSR_W-1:0]        w_divisor;
    logic [DVSR_W:0]          w_trial;
    logic                     w_fits;
    logic signed [35:0]       w_sum;
    logic                     w_take;
    logic                     w_set_ok;
    logic signed [13:0]       w_step_mag;
    logic signed [13:0]       w_cand;
    logic [LEVEL_W-1:0]       w_clamped;

    always_comb begin
        o_sts.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_sts.div_serial = (r_op == CMD_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_temp  <= '0;
            r_cycle_count <= COUNT_W'(1);
            r_learn_min   <= '0;
            r_learn_max   <= LEARN_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_TEMP:  r_start_temp  <= i_cfg_data[TEMP_W-1:0];
                REG_CYCLE_COUNT: r_cycle_count <= i_cfg_data[COUNT_W-1:0];
                REG_LEARN_MIN:   r_learn_min   <= i_cfg_data[LEVEL_W-1:0];
                REG_LEARN_MAX:   r_learn_max   <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_set_level <= i_set_level;
            r_count     <= i_valid_count;
            r_rand_acc  <= i_rand_accept;
            r_step_neg  <= i_rand_step[RAND_W-1];
            r_step_mag  <= i_rand_step[RAND_W-1] ? RAND_W'(-i_rand_step) : RAND_W'(i_rand_step);
        end
    end

    // One shared multiplier forms the duty product for a set and |r2|*temperature for a cycle end.
    always_comb begin
        if (r_op == CMD_SET) begin
            w_mult_a = {{(RAND_W-LEVEL_W){1'b0}}, r_set_level};
            w_mult_b = WRAP_K;
        end else begin
            w_mult_a = r_step_mag;
            w_mult_b = {{(DUTY_W-TEMP_W){1'b0}}, r_cur_temp};
        end
        w_prod    = {{DUTY_W{1'b0}}, w_mult_a} * {{RAND_W{1'b0}}, w_mult_b};
        w_delta   = $signed({1'b0, r_count}) - $signed({1'b0, r_prev_count});
        w_delta_x = {{19{w_delta[16]}}, w_delta};
        // 131068 is 2^17 - 4.
        w_term1   = (w_delta_x <<< 17) - (w_delta_x <<< 2);
        w_m       = (r_prev_count > COUNT_W'(1)) ? r_prev_count : COUNT_W'(1);
        w_term2   = $signed({{(33-RAND_W){r_rand_acc[RAND_W-1]}}, r_rand_acc}) *
                    $signed({{(33-COUNT_W){1'b0}}, w_m});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod  <= w_prod[DIV_W-1:0];
            r_term1 <= w_term1;
            r_term2 <= w_term2;
        end
    end

    always_comb begin
        w_recip_prod = {{DIV_W{1'b0}}, r_prod} * {{DIV_W{1'b0}}, SUPPLY_RECIP};
        w_duty_quo   = DIV_W'(w_recip_prod >> RECIP_SHIFT);
        // Division by 2^15 - 1: x = 32767*hi + (hi + lo), and hi + lo stays below twice 32767.
        w_k_sum    = {{(DVSR_W-(DIV_W-STEP_SHIFT)){1'b0}}, r_prod[DIV_W-1:STEP_SHIFT]} +
                     {1'b0, r_prod[STEP_SHIFT-1:0]};
        w_step_quo = {{STEP_SHIFT{1'b0}}, r_prod[DIV_W-1:STEP_SHIFT]} +
                     {{(DIV_W-1){1'b0}}, (w_k_sum >= STEP_DIVISOR)};

        // Only a start needs the serial divider; the other quotients are loaded finished.
        case (r_op)
            CMD_SET: begin
                w_dividend = w_duty_quo;
            end
            CMD_START: begin
                w_dividend = {{(DIV_W-TEMP_W){1'b0}}, r_start_temp};
            end
            default: begin
                w_dividend = w_step_quo;
            end
        endcase
        w_divisor = (r_cycle_count == '0) ? DVSR_W'(1) : r_cycle_count;
        w_trial   = {r_div_rem, r_div_quo[DIV_W-1]};
        w_fits    = (w_trial >= {1'b0, r_dvsr});
    end

    // Restoring division, one quotient bit a cycle; the quotient shifts in behind the dividend.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div_quo <= w_dividend;
            r_div_rem <= '0;
            r_dvsr    <= w_divisor;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_quo <= {r_div_quo[DIV_W-2:0], w_fits};
            r_div_rem <= w_fits ? DVSR_W'(w_trial - {1'b0, r_dvsr}) : w_trial[DVSR_W-1:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_comb begin
        w_sum      = r_term1 + {{3{r_term2[32]}}, r_term2};
        w_take     = !w_sum[35] && (w_sum != '0);
        w_set_ok   = (r_set_level >= SET_MIN_K) && (r_set_level <= SET_MAX_K);
        w_step_mag = $signed({2'b00, r_div_quo[LEVEL_W-1:0]});
        w_cand     = $signed({2'b00, r_cur_level}) + (r_step_neg ? -w_step_mag : w_step_mag);
        if (w_cand > $signed({2'b00, r_learn_max})) begin
            w_clamped = r_learn_max;
        end else if (w_cand < $signed({2'b00, r_learn_min})) begin
            w_clamped = r_learn_min;
        end else begin
            w_clamped = w_cand[LEVEL_W-1:0];
        end

        n_cur_level  = r_cur_level;
        n_best_level = r_best_level;
        n_cur_temp   = r_cur_temp;
        n_cool_step  = r_cool_step;
        n_prev_count = r_prev_count;
        n_duty       = r_duty;
        n_ok         = 1'b1;
        case (r_op)
            CMD_SET: begin
                n_ok = w_set_ok;
                if (w_set_ok) begin
                    n_cur_level = r_set_level;
                    n_duty = (r_div_quo > DIV_W'(DUTY_MAX)) ? DUTY_MAX : r_div_quo[DUTY_W-1:0];
                end
            end
            CMD_START: begin
                n_cur_temp  = r_start_temp;
                n_cool_step = r_div_quo[TEMP_W-1:0];
            end
            CMD_CYCLE: begin
                if (r_cur_temp != '0) begin
                    if (w_take) begin
                        n_best_level = r_cur_level;
                        n_prev_count = r_count;
                    end
                    if (r_cur_temp > r_cool_step) begin
                        n_cur_temp  = r_cur_temp - r_cool_step;
                        n_cur_level = w_clamped;
                    end else begin
                        n_cur_temp  = '0;
                        n_cur_level = n_best_level;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_level  <= DEFAULT_K;
            r_best_level <= '0;
            r_cur_temp   <= '0;
            r_cool_step  <= '0;
            r_prev_count <= '0;
            r_duty       <= DEFAULT_DUTY;
        end else if (i_cmd.commit) begin
            r_cur_level  <= n_cur_level;
            r_best_level <= n_best_level;
            r_cur_temp   <= n_cur_temp;
            r_cool_step  <= n_cool_step;
            r_prev_count <= n_prev_count;
            r_duty       <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_accepted    <= n_ok;
            o_level       <= n_cur_level;
            o_duty_count  <= n_duty;
            o_temperature <= n_cur_temp;
            o_learning    <= (n_cur_temp != '0);
        end
    end

endmodule

// ----- sv/tla_controller.sv -----
// Annealer sequencer: takes a command beat, steps the datapath through multiply and divide, hands out the result.
module tla_controller import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                if (i_sts.div_serial) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // The state update waits until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before its beat was taken");

    a_beat_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MUL))
        else $error("accepted beat did not start the multiply step");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_FIN))
        else $error("divider finished but sequencer did not move to finish");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside the finish step");
`endif

endmodule

// ----- sv/trigger_level_annealer.sv -----
// Top level of the trigger level annealer: command stream in, level report stream out.
//
//  Channel   Dir  Handshake          Payload
//  i_in      in   valid / ready      cmd, set_level, valid_count, rand_accept, rand_step
//  o_out     out  valid / ready      accepted, level, duty_count, temperature, learning
//  i_cfg_*   in   write enable only  register index, write data
//
// A start command goes from its input beat to its result through the capture of the beat, the
// multiply, the loading of the divider, the 28-bit serial restoring divider of the cooling step
// and the state update. Set and cycle-end commands skip the divider; their quotients come from
// a reciprocal multiply and a shift-and-compare by 32767. A new beat is taken once the result
// has been registered; a stalled output holds the sequencer in its finish step. Reset is
// synchronous and active low and leaves the level at its default.
module trigger_level_annealer import tla_pkg::*; #(
    parameter int PWM_WRAP   = 5000,
    parameter int SUPPLY_MV  = 3300,
    parameter int SET_MIN_MV = 0,
    parameter int SET_MAX_MV = 3300,
    parameter int DEFAULT_MV = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tla_in_if.sink                i_in,
    tla_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    tla_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tla_datapath #(
        .PWM_WRAP   (PWM_WRAP),
        .SUPPLY_MV  (SUPPLY_MV),
        .SET_MIN_MV (SET_MIN_MV),
        .SET_MAX_MV (SET_MAX_MV),
        .DEFAULT_MV (DEFAULT_MV)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_in.cmd),
        .i_set_level   (i_in.set_level),
        .i_valid_count (i_in.valid_count),
        .i_rand_accept (i_in.rand_accept),
        .i_rand_step   (i_in.rand_step),
        .o_accepted    (o_out.accepted),
        .o_level       (o_out.level),
        .o_duty_count  (o_out.duty_count),
        .o_temperature (o_out.temperature),
        .o_learning    (o_out.learning)
    );

endmodule
